>>> rtl/srs_pkg.sv
// Shared constants, types and state codes of the systematic particle resampler.
package srs_pkg;

  // Default sizing
  localparam int SRS_MAX_PARTICLES = 64;
  localparam int SRS_WEIGHT_BITS   = 16;

  // Fixed field widths
  localparam int OFFSET_BITS = 16;  // Q0.16 start offset, also the 1.0 scale
  localparam int WEIGHT_W    = 16;
  localparam int IDX_W       = 6;

  // Sequencer states
  typedef enum logic [2:0] {
    S_LOAD,   // collecting weights
    S_PREP,   // zero-total check, offset product, read of entry 0
    S_FIRST,  // walk starts on entry 0
    S_CMP,    // walk steps until the sample point is covered
    S_IDENT,  // zero total: identity index
    S_OUT     // result held until transfer
  } srs_state_t;

  // Sequencer to walk unit
  typedef struct packed {
    logic init;         // lhs = r * total
    logic first;        // walk = 0, cum_n = w0 * n
    logic search;       // step while the sample lies beyond cum
    logic next_sample;  // lhs += total * 1.0
  } srs_walk_ctl_t;

endpackage

>>> rtl/srs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/srs_walk.sv
// Walk unit: sample position, scaled cumulative weight, walk index and compare.
module srs_walk
  import srs_pkg::*;
#(
  parameter int MAX_PARTICLES = SRS_MAX_PARTICLES,
  parameter int WEIGHT_BITS   = SRS_WEIGHT_BITS,
  localparam int AW = $clog2(MAX_PARTICLES),
  localparam int CW = $clog2(MAX_PARTICLES + 1),
  localparam int TW = WEIGHT_BITS + AW,
  localparam int NW = TW + AW,
  localparam int LW = OFFSET_BITS + NW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  srs_walk_ctl_t          ctl,
  input  logic [OFFSET_BITS-1:0] offset,
  input  logic [TW-1:0]          total,
  input  logic [CW-1:0]          count,
  input  logic [WEIGHT_BITS-1:0] rdata,
  output logic [AW-1:0]          walk_index,
  output logic [AW-1:0]          walk_next,
  output logic                   step_ok
);

  logic [LW-1:0] lhs;       // (j*2^16 + r) * total
  logic [NW-1:0] cum_n;     // cumulative weight * n
  logic [NW-1:0] w_times_n;
  logic [LW-1:0] rhs;
  logic          room;
  logic          advance;

  // Weight scaled by the set size
  assign w_times_n = NW'(rdata) * NW'(count);

  // Step test: more particles ahead and sample beyond the covered mass
  assign rhs     = {cum_n, OFFSET_BITS'(0)};
  assign room    = (CW'(walk_index) + CW'(1)) < count;
  assign step_ok = room && (lhs > rhs);
  assign advance = ctl.search && step_ok;

  always_comb begin
    walk_next = walk_index;
    if (ctl.first) begin
      walk_next = '0;
    end else if (advance) begin
      walk_next = walk_index + AW'(1);
    end
  end

  // Sample position
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      lhs <= LW'(offset) * LW'(total);
    end else if (ctl.next_sample) begin
      lhs <= lhs + (LW'(total) << OFFSET_BITS);
    end
  end

  // Cumulative mass, advanced one entry per step
  always_ff @(posedge clk) begin
    if (ctl.first) begin
      cum_n <= w_times_n;
    end else if (advance) begin
      cum_n <= cum_n + w_times_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_index <= '0;
    end else begin
      walk_index <= walk_next;
    end
  end

endmodule

>>> rtl/systematic_particle_resampler_unit.sv
// Top level: weight loading, sequencer and result register of the resampler.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  item     | item_valid / item_ready     | weight, random_offset, last
//  result   | result_valid / result_ready | chosen_index, unchanged, last_out
//
// After the last item, setup runs through S_PREP and S_FIRST. Each result is then
// found in S_CMP, which steps the walk (at most n-1 steps over the set, one
// weight store read each), and held in S_OUT until its transfer. Zero-total
// sets go from S_PREP to S_IDENT, which gives each of their results. Items are
// taken only while loading; a stalled result holds the sequencer. Reset clears
// count, total and the sequencer; the weight store needs no clearing.
module systematic_particle_resampler_unit
  import srs_pkg::*;
#(
  parameter int MAX_PARTICLES = SRS_MAX_PARTICLES,
  parameter int WEIGHT_BITS   = SRS_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [WEIGHT_W-1:0]    weight,
  input  logic [OFFSET_BITS-1:0] random_offset,
  input  logic                   last,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [IDX_W-1:0]       chosen_index,
  output logic                   unchanged,
  output logic                   last_out
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int TW = WEIGHT_BITS + AW;

  srs_state_t             state, state_next;
  srs_walk_ctl_t          ctl;
  logic [CW-1:0]          count;
  logic [TW-1:0]          total;
  logic [OFFSET_BITS-1:0] offset;
  logic [AW-1:0]          j;
  logic                   ident;
  logic [WEIGHT_BITS-1:0] w;
  logic                   full;
  logic                   take;
  logic                   we;
  logic [AW-1:0]          raddr;
  logic [WEIGHT_BITS-1:0] rdata;
  logic [AW-1:0]          walk_index;
  logic [AW-1:0]          walk_next;
  logic                   step_ok;
  logic                   is_final;
  logic                   out_xfer;

  // Weight masked to its stored width
  assign w          = WEIGHT_BITS'(weight);
  assign full       = (count == CW'(MAX_PARTICLES));
  assign item_ready = (state == S_LOAD);
  assign take       = item_valid && item_ready;
  assign we         = take && !full;
  assign is_final   = (CW'(j) + CW'(1)) == count;
  assign out_xfer   = result_valid && result_ready;
  assign raddr      = (state == S_PREP) ? '0 : (walk_next + AW'(1));

  srs_ram #(
    .WIDTH(WEIGHT_BITS),
    .DEPTH(MAX_PARTICLES)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count[AW-1:0]),
    .wdata(w),
    .raddr(raddr),
    .rdata(rdata)
  );

  srs_walk #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .offset    (offset),
    .total     (total),
    .count     (count),
    .rdata     (rdata),
    .walk_index(walk_index),
    .walk_next (walk_next),
    .step_ok   (step_ok)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and walk controls
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_LOAD: begin
        if (take && last) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        ctl.init = 1'b1;
        if (total == '0) begin
          state_next = S_IDENT;
        end else begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        ctl.first  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        ctl.search = 1'b1;
        if (!step_ok) begin
          state_next = S_OUT;
        end
      end
      S_IDENT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_xfer) begin
          if (is_final) begin
            state_next = S_LOAD;
          end else begin
            ctl.next_sample = 1'b1;
            state_next      = ident ? S_IDENT : S_CMP;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Count, total and set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      j     <= '0;
      ident <= 1'b0;
    end else begin
      if (we) begin
        count <= count + CW'(1);
        total <= total + TW'(w);
      end
      if (state == S_PREP) begin
        j     <= '0;
        ident <= (total == '0);
      end
      if (state == S_OUT && out_xfer) begin
        if (is_final) begin
          count <= '0;
          total <= '0;
        end else begin
          j <= j + AW'(1);
        end
      end
    end
  end

  // Start offset, kept from the closing item
  always_ff @(posedge clk) begin
    if (take && last) begin
      offset <= random_offset;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_CMP && !step_ok) begin
      result_valid <= 1'b1;
    end else if (state == S_IDENT) begin
      result_valid <= 1'b1;
    end else if (out_xfer) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CMP && !step_ok) begin
      chosen_index <= IDX_W'(walk_index);
      unchanged    <= 1'b0;
      last_out     <= is_final;
    end else if (state == S_IDENT) begin
      chosen_index <= IDX_W'(j);
      unchanged    <= 1'b1;
      last_out     <= is_final;
    end
  end

endmodule

>>> verif/tb.sv
// Testbench for the systematic particle resampler: scoreboard, drivers and run control.
module tb
  import srs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS    = 380;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int REPORT_LIMIT = 10;

  // One selected index as the block should present it
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             identity;
    logic             closing;
  } pick_t;

  // Kinds of weight content in a set
  typedef enum int {SET_RANDOM, SET_ZERO, SET_SPARSE, SET_TINY} set_kind_t;

  // Idle patterns on the two channels
  typedef enum int {PH_STEADY, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH} idle_phase_t;

  // Scoreboard: predicts the resampled indices and checks them in order
  class resample_scoreboard;
    bit [WEIGHT_W-1:0] held_weight [SRS_MAX_PARTICLES];
    int unsigned       held_count;
    longint unsigned   weight_sum;
    pick_t             expected_picks[$];
    int unsigned       accepted_items;
    int unsigned       failures;

    function new();
      held_count     = 0;
      weight_sum     = 0;
      accepted_items = 0;
      failures       = 0;
    endfunction

    // Append one prediction at the tail
    function void queue_pick(pick_t p);
      expected_picks.insert(expected_picks.size(), p);
    endfunction

    // Walk the cumulative weights once across all sample points, no division
    function void resample_set(bit [OFFSET_BITS-1:0] offset);
      int unsigned     n;
      int unsigned     walk;
      longint unsigned cum;
      longint unsigned sample_point;
      pick_t           p;
      n    = held_count;
      walk = 0;
      cum  = held_weight[0];
      for (int unsigned s = 0; s < n; s++) begin
        if (weight_sum == 0) begin
          p.index = IDX_W'(s);
        end else begin
          sample_point = ((longint'(s) << OFFSET_BITS) + offset) * weight_sum;
          // clamp at the last particle
          while (walk + 1 < n && sample_point > (cum * n) << OFFSET_BITS) begin
            walk++;
            cum += held_weight[walk];
          end
          p.index = IDX_W'(walk);
        end
        p.identity = (weight_sum == 0);
        p.closing  = (s + 1 == n);
        queue_pick(p);
      end
      held_count = 0;
      weight_sum = 0;
    endfunction

    // Accepted item transfer: store unless full, resample on last
    function void take_weight(bit [WEIGHT_W-1:0] w, bit [OFFSET_BITS-1:0] offset, bit closes);
      accepted_items++;
      if (held_count < SRS_MAX_PARTICLES) begin
        held_weight[held_count] = w;
        held_count++;
        weight_sum += w;
      end
      if (closes) resample_set(offset);
    endfunction

    // Accepted result transfer: compare with the oldest prediction
    function void check_pick(logic [IDX_W-1:0] index, logic identity, logic closing);
      pick_t want;
      if (expected_picks.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: index %0d unchanged %b last_out %b",
                   index, identity, closing);
        return;
      end
      want = expected_picks.pop_front();
      if (index !== want.index || identity !== want.identity || closing !== want.closing) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch: expected index %0d unchanged %b last_out %b, got %0d %b %b",
                   want.index, want.identity, want.closing, index, identity, closing);
      end
    endfunction
  endclass

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   item_valid    = 1'b0;
  logic                   item_ready;
  logic [WEIGHT_W-1:0]    weight        = '0;
  logic [OFFSET_BITS-1:0] random_offset = '0;
  logic                   last          = 1'b0;
  logic                   result_valid;
  logic                   result_ready  = 1'b0;
  logic [IDX_W-1:0]       chosen_index;
  logic                   unchanged;
  logic                   last_out;

  resample_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  bit  hold_results  = 1'b0;
  int  items_sent    = 0;

  systematic_particle_resampler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .weight       (weight),
    .random_offset(random_offset),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .chosen_index (chosen_index),
    .unchanged    (unchanged),
    .last_out     (last_out)
  );

  always #5ns clk = ~clk;

  // Idle pattern for both channels
  task automatic set_phase(idle_phase_t ph);
    case (ph)
      PH_STEADY: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      PH_SENDER_IDLE: begin
        send_idle_pct = 77;
        stall_pct     = 0;
      end
      PH_RECEIVER_STALL: begin
        send_idle_pct = 0;
        stall_pct     = 77;
      end
      default: begin
        send_idle_pct = 16;
        stall_pct     = 16;
      end
    endcase
  endtask

  // Offer one item and wait for its transfer
  task automatic send_weight(bit [WEIGHT_W-1:0] w, bit [OFFSET_BITS-1:0] offset, bit closes);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid    <= 1'b1;
    weight        <= w;
    random_offset <= offset;
    last          <= closes;
    do @(posedge clk); while (!item_ready);
    sb.take_weight(w, offset, closes);
    items_sent++;
  endtask

  // A set with fixed weights and start offset
  task automatic send_fixed(bit [WEIGHT_W-1:0] ws[$], bit [OFFSET_BITS-1:0] offset);
    foreach (ws[i]) begin
      if (i == ws.size() - 1) send_weight(ws[i], offset, 1'b1);
      else send_weight(ws[i], OFFSET_BITS'($urandom_range(65535)), 1'b0);
    end
  endtask

  // A set of random content; sizes past the store depth drop the extra weights
  task automatic send_random_set(int size, set_kind_t kind);
    bit [WEIGHT_W-1:0] w;
    for (int i = 0; i < size; i++) begin
      case (kind)
        SET_ZERO:   w = '0;
        SET_SPARSE: w = ($urandom_range(3) == 0) ? WEIGHT_W'($urandom_range(65535)) : '0;
        SET_TINY:   w = WEIGHT_W'($urandom_range(3));
        default:    w = WEIGHT_W'($urandom_range(65535));
      endcase
      send_weight(w, OFFSET_BITS'($urandom_range(65535)), i == size - 1);
    end
  endtask

  // Result side: random ready, held low during the pressure window
  initial begin
    while (rst) @(posedge clk);
    forever begin
      result_ready <= !hold_results && ($urandom_range(99) >= stall_pct);
      @(posedge clk);
      if (result_valid && result_ready) sb.check_pick(chosen_index, unchanged, last_out);
    end
  end

  // Long receiver hold-off while items keep coming, to back up the input
  initial begin
    do @(posedge clk); while (sb.accepted_items < 30);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  // Stimulus and end of run
  initial begin
    int          set_no;
    int          roll;
    int          size;
    set_kind_t   kind;
    set_no = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_phase(PH_STEADY);

    // Directed sets: single particle, zero total, full-scale weights, trailing zeros
    send_fixed('{16'hFFFF}, 16'h0000);
    send_fixed('{16'h0000}, 16'hFFFF);
    send_fixed('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 16'hFFFF);
    send_fixed('{16'h0000, 16'h0000, 16'h0000}, 16'h1234);
    send_fixed('{16'h0000, 16'h0000, 16'hFFFF}, 16'h0000);
    send_fixed('{16'h0001, 16'h0000, 16'h0000}, 16'hFFFF);
    send_fixed('{16'h8000, 16'h0001, 16'h7FFF, 16'h5555, 16'hAAAA}, 16'h8000);

    // Full store, then one that overflows
    send_random_set(SRS_MAX_PARTICLES, SET_RANDOM);
    send_random_set(SRS_MAX_PARTICLES + 2, SET_SPARSE);

    // Random sets, idle pattern rotating every three sets
    while (items_sent < NUM_ITEMS) begin
      set_phase(idle_phase_t'((set_no / 3) % 4));
      roll = $urandom_range(99);
      if (roll < 3) size = SRS_MAX_PARTICLES;
      else if (roll < 6) size = SRS_MAX_PARTICLES + $urandom_range(1, 4);
      else size = $urandom_range(1, 12);
      roll = $urandom_range(99);
      if (roll < 10) kind = SET_ZERO;
      else if (roll < 25) kind = SET_SPARSE;
      else if (roll < 35) kind = SET_TINY;
      else kind = SET_RANDOM;
      send_random_set(size, kind);
      set_no++;
    end
    item_valid <= 1'b0;

    while (sb.expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_picks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/srs_walk.sv
rtl/systematic_particle_resampler_unit.sv
verif/tb.sv
